@@ hdl/tnms_pkg.sv @@
package tnms_pkg;

    localparam int PIX_W      = 24;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 10;
    localparam int DIM_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int WIN        = 5;
    localparam int LINES      = WIN - 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd2;

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [PIX_W-1:0] RST_THRESHOLD    = 24'd3277;
    localparam logic [DIM_W-1:0] MIN_DIM          = 11'd3;

    typedef struct packed {
        logic [LINES-1:0][PIX_W-1:0] lines;
        logic [PIX_W-1:0]            pix;
        logic [COL_W-1:0]            col;
        logic [ROW_W-1:0]            row;
        logic                        last_col;
        logic                        last_row;
    } t_column;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] res;
        if (v < MIN_DIM) res = MIN_DIM;
        else if (v > hi) res = hi;
        else res = v;
        return res;
    endfunction

endpackage

@@ hdl/tnms_ram.sv @@
module tnms_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/tnms_core.sv @@
module tnms_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_col_valid,
    input  tnms_pkg::t_column        i_col,
    input  logic [tnms_pkg::PIX_W-1:0] i_threshold,
    output logic                     o_take,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_is_maximum,
    output logic [tnms_pkg::COL_W-1:0] o_center_col,
    output logic [tnms_pkg::ROW_W-1:0] o_center_row,
    output logic                     o_last_of_run
);
    import tnms_pkg::*;

    logic [PIX_W-1:0] r_win [WIN][WIN];
    logic             r_job_valid;
    logic [COL_W-1:0] r_job_col;
    logic [ROW_W-1:0] r_job_row;
    logic             r_job_lc;
    logic             r_job_lr;
    logic [1:0]       r_ri_off;
    logic [1:0]       r_ci_off;
    logic             r_out_valid;
    logic             r_out_max;
    logic [COL_W-1:0] r_out_col;
    logic [ROW_W-1:0] r_out_row;
    logic             r_out_last;

    logic             emit;
    logic             job_last;
    logic             keep;
    logic [2:0]       ri;
    logic [2:0]       ci;
    logic [PIX_W-1:0] centre;
    logic [1:0]       ri_max;
    logic [1:0]       ci_max;

    assign ri_max   = r_job_lr ? 2'd2 : 2'd0;
    assign ci_max   = r_job_lc ? 2'd2 : 2'd0;
    assign ri       = 3'd2 + {1'b0, r_ri_off};
    assign ci       = 3'd2 + {1'b0, r_ci_off};
    assign job_last = (r_ri_off == ri_max) && (r_ci_off == ci_max);
    assign emit     = r_job_valid && (!r_out_valid || i_out_ready);
    assign o_take   = !r_job_valid || (emit && job_last);
    assign centre   = r_win[ri][ci];

    always_comb begin
        keep = $signed(centre) >= $signed(i_threshold);
        for (int nr = 0; nr < WIN; nr++) begin
            for (int nc = 0; nc < WIN; nc++) begin
                if ((nr + 2 >= int'(ri)) && (nr <= int'(ri) + 2) &&
                    (nc + 2 >= int'(ci)) && (nc <= int'(ci) + 2) &&
                    !(nr == int'(ri) && nc == int'(ci)) &&
                    (int'(r_job_row) + nr >= 4) && (int'(r_job_col) + nc >= 4) &&
                    ($signed(r_win[nr][nc]) > $signed(centre))) begin
                    keep = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < WIN; k++) begin
                for (int j = 0; j < WIN; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
                r_out_max   <= keep;
                r_out_col   <= r_job_col + COL_W'(ci) - COL_W'(4);
                r_out_row   <= r_job_row + ROW_W'(ri) - ROW_W'(4);
                r_out_last  <= job_last;
                if (!job_last) begin
                    if (r_ci_off == ci_max) begin
                        r_ci_off <= 2'd0;
                        r_ri_off <= r_ri_off + 2'd1;
                    end else begin
                        r_ci_off <= r_ci_off + 2'd1;
                    end
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_take) begin
                r_job_valid <= i_col_valid && (i_col.row >= ROW_W'(2)) &&
                               (i_col.col >= COL_W'(2));
                if (i_col_valid) begin
                    for (int k = 0; k < WIN; k++) begin
                        for (int j = 0; j < WIN - 1; j++) begin
                            r_win[k][j] <= r_win[k][j+1];
                        end
                    end
                    for (int k = 0; k < LINES; k++) begin
                        r_win[k][WIN-1] <= i_col.lines[k];
                    end
                    r_win[WIN-1][WIN-1] <= i_col.pix;
                    r_job_col   <= i_col.col;
                    r_job_row   <= i_col.row;
                    r_job_lc    <= i_col.last_col;
                    r_job_lr    <= i_col.last_row;
                    r_ri_off    <= 2'd0;
                    r_ci_off    <= 2'd0;
                end
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_is_maximum = r_out_max;
    assign o_center_col = r_out_col;
    assign o_center_row = r_out_row;
    assign o_last_of_run = r_out_last;

    a_offsets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_ri_off <= ri_max) && (r_ci_off <= ci_max))
        else $error("window offset beyond run");
    a_job_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_job_row >= ROW_W'(2)) && (r_job_col >= COL_W'(2)))
        else $error("run started without a complete window");
    a_run_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !job_last) |=> r_job_valid)
        else $error("run ended early");
endmodule

@@ hdl/threshold_nonmax_suppression_5x5_unit.sv @@
// channel   | valid        | ready        | payload
// input     | i_in_valid   | o_in_ready   | i_response
// result    | o_out_valid  | i_out_ready  | o_is_maximum, o_center_col, o_center_row, o_last_of_run
// config    | i_cfg_we     | -            | i_cfg_index, i_cfg_wdata
// One pixel per cycle while the output is not stalled and each pixel releases at most one result;
// a pixel releasing n results holds the input until all are sent (up to 9 on the frame's last pixel).
// Line stores are read as a pixel enters the s1 register; window and job registers update when the
// core takes the column, the judge is combinational on the window, and the result register follows.
// Synchronous active-low reset clears counters, window and pipeline valids; line
// stores are not cleared. A stalled result register stalls the judge and the input.
module threshold_nonmax_suppression_5x5_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [tnms_pkg::PIX_W-1:0] i_response,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_is_maximum,
    output logic [tnms_pkg::COL_W-1:0]        o_center_col,
    output logic [tnms_pkg::ROW_W-1:0]        o_center_row,
    output logic                              o_last_of_run,
    input  logic                              i_cfg_we,
    input  logic [tnms_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tnms_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import tnms_pkg::*;

    logic [DIM_W-1:0] r_frame_width;
    logic [DIM_W-1:0] r_frame_height;
    logic [PIX_W-1:0] r_threshold;
    logic [COL_W-1:0] r_col_count;
    logic [ROW_W-1:0] r_row_count;
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pix;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic             r_s1_lc;
    logic             r_s1_lr;

    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic             col_wrap;
    logic [COL_W-1:0] cur_col;
    logic [DIM_W-1:0] row_inc;
    logic [ROW_W-1:0] cur_row;
    logic [DIM_W-1:0] nxt_col;
    logic [DIM_W-1:0] nxt_row;
    logic [COL_W-1:0] n_col_count;
    logic [ROW_W-1:0] n_row_count;
    logic             in_accept;
    logic             take;
    logic [PIX_W-1:0] rdata [LINES];
    t_column          col_item;

    assign w_eff    = clamp_dim(r_frame_width, DIM_W'(MAX_WIDTH));
    assign h_eff    = clamp_dim(r_frame_height, DIM_W'(MAX_HEIGHT));
    assign col_wrap = {1'b0, r_col_count} >= w_eff;
    assign cur_col  = col_wrap ? '0 : r_col_count;
    assign row_inc  = {1'b0, r_row_count} + (col_wrap ? DIM_W'(1) : DIM_W'(0));
    assign cur_row  = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    assign nxt_col  = {1'b0, cur_col} + DIM_W'(1);
    assign nxt_row  = {1'b0, cur_row} + DIM_W'(1);

    always_comb begin
        if (nxt_col >= w_eff) begin
            n_col_count = '0;
            n_row_count = (nxt_row >= h_eff) ? '0 : nxt_row[ROW_W-1:0];
        end else begin
            n_col_count = nxt_col[COL_W-1:0];
            n_row_count = cur_row;
        end
    end

    assign o_in_ready = !r_s1_valid || take;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_threshold    <= RST_THRESHOLD;
            r_col_count    <= '0;
            r_row_count    <= '0;
            r_s1_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[DIM_W-1:0];
                    CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[DIM_W-1:0];
                    CFG_THRESHOLD:    r_threshold    <= i_cfg_wdata[PIX_W-1:0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_col_count <= n_col_count;
                r_row_count <= n_row_count;
                r_s1_valid  <= 1'b1;
                r_s1_pix    <= i_response;
                r_s1_col    <= cur_col;
                r_s1_row    <= cur_row;
                r_s1_lc     <= ({1'b0, cur_col} == w_eff - DIM_W'(1));
                r_s1_lr     <= ({1'b0, cur_row} == h_eff - DIM_W'(1));
            end else if (take) begin
                r_s1_valid  <= 1'b0;
            end
        end
    end

    for (genvar k = 0; k < LINES; k++) begin : g_line
        tnms_ram #(
            .WIDTH(PIX_W),
            .DEPTH(MAX_WIDTH)
        ) u_line (
            .i_clk  (i_clk),
            .i_we   (r_s1_valid && take),
            .i_waddr(r_s1_col),
            .i_wdata((k == LINES - 1) ? r_s1_pix : rdata[(k + 1) % LINES]),
            .i_re   (in_accept),
            .i_raddr(cur_col),
            .o_rdata(rdata[k])
        );
        assign col_item.lines[k] = rdata[k];
    end

    assign col_item.pix      = r_s1_pix;
    assign col_item.col      = r_s1_col;
    assign col_item.row      = r_s1_row;
    assign col_item.last_col = r_s1_lc;
    assign col_item.last_row = r_s1_lr;

    tnms_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_col_valid  (r_s1_valid),
        .i_col        (col_item),
        .i_threshold  (r_threshold),
        .o_take       (take),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_is_maximum (o_is_maximum),
        .o_center_col (o_center_col),
        .o_center_row (o_center_row),
        .o_last_of_run(o_last_of_run)
    );
endmodule
